/* design/srtt_pkg.sv */
// Shared types and constants for the signed radix-to-text converter.
// Used by srtt_ctrl, srtt_dpath and signed_radix_to_text_core; no dependencies.
package srtt_pkg;

    localparam int unsigned MAX_RADIX = 16;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned RADIX_W   = 5;
    localparam int unsigned SYM_W     = 64;
    localparam int unsigned NUM_SYM   = 16;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned DEPTH     = 32;
    localparam int unsigned DEPTH_W   = 6;
    localparam int unsigned PTR_W     = 5;
    localparam int unsigned STEP_BITS = 8;
    localparam int unsigned CHUNKS    = VALUE_W / STEP_BITS;
    localparam int unsigned CHUNK_W   = $clog2(CHUNKS);
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 5'd10;
    localparam logic [SYM_W-1:0]   SYM_LO_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [SYM_W-1:0]   SYM_HI_RESET  = 64'h4645_4443_4241_3938;

    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0]  CHAR_NUL   = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX  = 2'd0,
        CFG_SYM_LO = 2'd1,
        CFG_SYM_HI = 2'd2
    } srtt_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } srtt_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic emit_minus;
        logic emit_digit;
    } srtt_cmd_t;

    typedef struct packed {
        logic alpha_ok;
        logic neg;
        logic quot_zero;
        logic depth_one;
        logic out_free;
    } srtt_status_t;

endpackage

/* design/srtt_ctrl.sv */
// Controller state machine for the signed radix-to-text converter.
// Depends on srtt_pkg; drives srtt_dpath through command and status structs.
module srtt_ctrl
    import srtt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  srtt_status_t status,
    output srtt_cmd_t    cmd
);

    srtt_state_t          state_reg, state_next;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chunk_reg <= '0;
        end else begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        chunk_next = chunk_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                chunk_next = '0;
                state_next = status.alpha_ok ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (chunk_reg == CHUNK_W'(CHUNKS - 1)) begin
                    cmd.push   = 1'b1;
                    chunk_next = '0;
                    if (status.quot_zero) begin
                        state_next = ST_SIGN;
                    end
                end else begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            ST_SIGN: begin
                if (!status.neg) begin
                    state_next = ST_EMIT;
                end else if (status.out_free) begin
                    cmd.emit_minus = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.depth_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/srtt_dpath.sv */
// Datapath for the signed radix-to-text converter: configuration registers,
// alphabet check, 8-bit-per-cycle divider, digit stack and output register.
// Depends on srtt_pkg; commanded by srtt_ctrl.
module srtt_dpath
    import srtt_pkg::*;
#(
    parameter int unsigned RADIX_MAX = MAX_RADIX
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [VALUE_W-1:0]   s_tdata,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SYM_W-1:0]     cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [CHAR_W-1:0]    m_tdata,
    output logic                 m_tlast,
    input  srtt_cmd_t            cmd,
    output srtt_status_t         status
);

    logic [RADIX_W-1:0]   radix_reg;
    logic [SYM_W-1:0]     sym_lo_reg;
    logic [SYM_W-1:0]     sym_hi_reg;

    logic [VALUE_W-1:0]   w_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic                 neg_reg;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [DIGIT_W-1:0]   dig_stack [DEPTH];

    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic                 out_last_reg;

    logic [2*SYM_W-1:0]   sym_all;
    logic [CHAR_W-1:0]    sym [NUM_SYM];
    logic                 alpha_bad;
    logic                 range_ok;

    logic [DIGIT_W-1:0]   div_r;
    logic [DIGIT_W:0]     div_r2;
    logic [VALUE_W-1:0]   div_w;
    logic [PTR_W-1:0]     rd_ptr;
    logic [DEPTH_W-1:0]   depth_dec;
    logic                 out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg  <= RADIX_RESET;
            sym_lo_reg <= SYM_LO_RESET;
            sym_hi_reg <= SYM_HI_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RADIX:  radix_reg  <= cfg_data[RADIX_W-1:0];
                CFG_SYM_LO: sym_lo_reg <= cfg_data;
                CFG_SYM_HI: sym_hi_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign sym_all = {sym_hi_reg, sym_lo_reg};

    always_comb begin
        alpha_bad = 1'b0;
        for (int i = 0; i < NUM_SYM; i++) begin
            sym[i] = sym_all[CHAR_W*i +: CHAR_W];
        end
        for (int i = 0; i < NUM_SYM; i++) begin
            if (RADIX_W'(i) < radix_reg) begin
                if (sym[i] == CHAR_NUL || sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS) begin
                    alpha_bad = 1'b1;
                end
                for (int j = i + 1; j < NUM_SYM; j++) begin
                    if (RADIX_W'(j) < radix_reg && sym[i] == sym[j]) begin
                        alpha_bad = 1'b1;
                    end
                end
            end
        end
        range_ok = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(RADIX_MAX));
    end

    always_comb begin
        div_r  = rem_reg;
        div_w  = w_reg;
        div_r2 = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            div_r2 = {div_r, div_w[VALUE_W-1]};
            div_w  = {div_w[VALUE_W-2:0], 1'b0};
            if (div_r2 >= radix_reg) begin
                div_r2   = div_r2 - radix_reg;
                div_w[0] = 1'b1;
            end
            div_r = div_r2[DIGIT_W-1:0];
        end
    end

    assign depth_dec = depth_reg - 1'b1;
    assign rd_ptr    = depth_dec[PTR_W-1:0];
    assign out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else if (cmd.load) begin
            depth_reg <= '0;
        end else if (cmd.push) begin
            depth_reg <= depth_reg + 1'b1;
        end else if (cmd.emit_digit) begin
            depth_reg <= depth_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg <= s_tdata[VALUE_W-1];
            w_reg   <= s_tdata[VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            w_reg   <= div_w;
            rem_reg <= cmd.push ? '0 : div_r;
        end
        if (cmd.push) begin
            dig_stack[depth_reg[PTR_W-1:0]] <= div_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_minus || cmd.emit_digit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_minus) begin
            out_char_reg <= CHAR_MINUS;
            out_last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            out_char_reg <= sym[dig_stack[rd_ptr]];
            out_last_reg <= (depth_reg == DEPTH_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    assign status.alpha_ok  = range_ok && !alpha_bad;
    assign status.neg       = neg_reg;
    assign status.quot_zero = (div_w == '0);
    assign status.depth_one = (depth_reg == DEPTH_W'(1));
    assign status.out_free  = out_free;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(DEPTH))
        else $error("digit stack depth out of range");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> depth_reg < DEPTH_W'(DEPTH))
        else $error("digit pushed onto a full stack");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_digit |-> depth_reg != '0)
        else $error("digit popped from an empty stack");

    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> {1'b0, rem_reg} < radix_reg)
        else $error("partial remainder not below radix");

    a_minus_only_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_minus |-> neg_reg && depth_reg != '0)
        else $error("minus sign emitted for a non-negative item");
`endif

endmodule

/* design/signed_radix_to_text_core.sv */
// Top level of the signed radix-to-text converter.
// Depends on srtt_pkg, srtt_ctrl and srtt_dpath.
//
//  channel | ports                                   | contents
//  --------+-----------------------------------------+----------------------------------
//  input   | s_tvalid s_tready s_tdata[31:0]         | value (signed)
//  output  | m_tvalid m_tready m_tdata[7:0] m_tlast  | character; tlast = last character
//  config  | cfg_valid cfg_ready cfg_index cfg_data  | 0 radix, 1 symbols 0-7, 2 symbols 8-15
//
// An item goes through these steps in order: accept, alphabet check, divider steps
// for each digit (8 dividend bits each), a sign step that may emit a minus, and one
// character out per digit. A rejected alphabet returns to idle without output.
// Reset is synchronous, active low, and restores radix 10 and symbols "0-9A-F".
// A stalled output holds the converter; the next item is taken while the final
// character still waits in the output register.
module signed_radix_to_text_core
    import srtt_pkg::*;
#(
    parameter int unsigned RADIX_MAX = MAX_RADIX
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VALUE_W-1:0]   s_tdata,    // [31:0] value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CHAR_W-1:0]    m_tdata,    // [7:0] character
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SYM_W-1:0]     cfg_data
);

    srtt_cmd_t    cmd;
    srtt_status_t status;

    assign cfg_ready = 1'b1;

    srtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srtt_dpath #(
        .RADIX_MAX (RADIX_MAX)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
